// ===== hdl/mme_pkg.sv =====
// shared types and constants of the matrix multiply engine
package mme_pkg;

	localparam int DIM_W   = 4;   // config register and write index width
	localparam int VAL_W   = 16;  // input element width
	localparam int OUT_W   = 36;  // result element width
	localparam int POS_W   = 3;   // out_row / out_col width

	localparam logic [1:0] KIND_WR_A    = 2'd0;
	localparam logic [1:0] KIND_WR_B    = 2'd1;
	localparam logic [1:0] KIND_COMPUTE = 2'd2;

	localparam logic [1:0] CFG_A_ROWS    = 2'd0;
	localparam logic [1:0] CFG_INNER_DIM = 2'd1;
	localparam logic [1:0] CFG_B_COLS    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STATUS,
		ST_ISSUE,
		ST_WAIT
	} mme_state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic wr_add;
	} mme_mem_ctrl_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mme_tag_t;

	typedef struct packed {
		logic             load;
		logic             status;
		logic             last;
		logic             is_comp;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} mme_res_t;

endpackage

// ===== hdl/mme_store.sv =====
// matrix element store with per-entry valid bits and saturating update
module mme_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int EW    = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mme_pkg::mme_mem_ctrl_t       ctrl,
	input  logic [AW-1:0]                rd_addr,
	input  logic [AW-1:0]                wr_addr,
	input  logic signed [mme_pkg::VAL_W-1:0] wr_value,
	output logic signed [EW-1:0]         rd_data
);

	localparam int SUM_W = ((EW > mme_pkg::VAL_W) ? EW : mme_pkg::VAL_W) + 1;
	localparam logic signed [SUM_W-1:0] EHI = SUM_W'((64'sd1 <<< (EW - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] ELO = ~EHI;

	logic signed [EW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0]        vld_q;
	logic signed [EW-1:0]    mem_rd_q;
	logic                    hit_q;
	logic signed [SUM_W-1:0] sum;
	logic signed [EW-1:0]    new_val;

	assign rd_data = mem_rd_q & {EW{hit_q}};

	// read data of the same cell was fetched when the write beat was taken
	always_comb begin
		sum = (ctrl.wr_add ? SUM_W'(rd_data) : {SUM_W{1'b0}}) + SUM_W'(wr_value);
		if (sum > EHI) begin
			new_val = EW'(EHI);
		end else if (sum < ELO) begin
			new_val = EW'(ELO);
		end else begin
			new_val = EW'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= new_val;
		end
		if (ctrl.rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (ctrl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				hit_q <= vld_q[rd_addr];
			end
		end
	end

endmodule

// ===== hdl/mme_mac.sv =====
// shared multiply-accumulate unit: registered product, clamp, accumulate, saturate
module mme_mac #(
	parameter int MAX_DIM = 8,
	parameter int EW      = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mme_pkg::mme_tag_t                tag,
	input  logic                             clear,
	input  logic signed [EW-1:0]             a,
	input  logic signed [EW-1:0]             b,
	output logic                             done,
	output logic signed [mme_pkg::OUT_W-1:0] result
);

	localparam int PROD_W = 2 * EW;
	localparam int CLMP_W = (PROD_W > 60) ? 60 : PROD_W;
	localparam int ACC_W  = (CLMP_W + $clog2(MAX_DIM) > mme_pkg::OUT_W) ?
		CLMP_W + $clog2(MAX_DIM) : mme_pkg::OUT_W;
	localparam int OW     = mme_pkg::OUT_W;

	mme_pkg::mme_tag_t        tag_s1;
	mme_pkg::mme_tag_t        tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [CLMP_W-1:0] pclamp;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     done_q;
	logic                     sign;
	logic                     ovf;

	generate
		if (PROD_W > CLMP_W) begin : g_clamp
			localparam logic signed [PROD_W-1:0] PHI = PROD_W'(64'sd1 <<< 58);
			localparam logic signed [PROD_W-1:0] PLO = -PHI;
			always_comb begin
				if (prod_s2 > PHI) begin
					pclamp = CLMP_W'(PHI);
				end else if (prod_s2 < PLO) begin
					pclamp = CLMP_W'(PLO);
				end else begin
					pclamp = CLMP_W'(prod_s2);
				end
			end
		end else begin : g_pass
			assign pclamp = prod_s2;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= tag;
			tag_s2 <= tag_s1;
			if (clear) begin
				done_q <= 1'b0;
			end else if (tag_s2.valid && tag_s2.last) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tag_s1.valid) begin
			prod_s2 <= a * b;
		end
		if (tag_s2.valid) begin
			acc_q <= tag_s2.first ? ACC_W'(pclamp) : acc_q + ACC_W'(pclamp);
		end
	end

	// top bits must all match the sign or the sum is out of 36-bit range
	assign sign = acc_q[ACC_W-1];
	assign ovf  = sign ? ~&acc_q[ACC_W-1:OW-1] : |acc_q[ACC_W-1:OW-1];

	always_comb begin
		if (!ovf) begin
			result = acc_q[OW-1:0];
		end else if (sign) begin
			result = {1'b1, {(OW - 1){1'b0}}};
		end else begin
			result = {1'b0, {(OW - 1){1'b1}}};
		end
	end

	assign done = done_q;

`ifndef SYNTHESIS
	a_no_product_while_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !tag_s1.valid)
		else $error("product entered while a finished sum waits");
`endif

endmodule

// ===== hdl/mme_seq.sv =====
// sequencer: write read-modify-write and the row/col/k walk of a compute beat
module mme_seq #(
	parameter int MAX_DIM = 8,
	parameter int AW      = 6,
	parameter int IDX_W   = 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [mme_pkg::DIM_W-1:0]         row,
	input  logic [mme_pkg::DIM_W-1:0]         col,
	input  logic signed [mme_pkg::VAL_W-1:0]  value,
	input  logic                              add_to_cell,
	input  logic [mme_pkg::DIM_W-1:0]         nr,
	input  logic [mme_pkg::DIM_W-1:0]         nk,
	input  logic [mme_pkg::DIM_W-1:0]         nc,
	input  logic                              out_free,
	input  logic                              mac_done,
	output mme_pkg::mme_mem_ctrl_t            ctrl_a,
	output mme_pkg::mme_mem_ctrl_t            ctrl_b,
	output logic [AW-1:0]                     rd_addr_a,
	output logic [AW-1:0]                     rd_addr_b,
	output logic [AW-1:0]                     wr_addr,
	output logic signed [mme_pkg::VAL_W-1:0]  wr_value,
	output mme_pkg::mme_tag_t                 tag,
	output logic                              mac_clear,
	output mme_pkg::mme_res_t                 res
);

	localparam int DW = mme_pkg::DIM_W;

	mme_pkg::mme_state_t state_q, state_d;
	logic [IDX_W-1:0]    r_q, c_q, k_q;
	logic                err_q;
	logic                tgt_b_q;
	logic [AW-1:0]       wr_addr_q;
	logic signed [mme_pkg::VAL_W-1:0] value_q;
	logic                add_q;
	logic [DW-1:0]       rlim, clim;
	logic                oob;
	logic [AW-1:0]       in_addr;
	logic                k_last, c_last, r_last, elem_last;
	logic                accept;

	function automatic logic [AW-1:0] cell_addr(logic [IDX_W-1:0] ri, logic [IDX_W-1:0] ci);
		return AW'(ri) * AW'(MAX_DIM) + AW'(ci);
	endfunction

	assign rlim    = (kind == mme_pkg::KIND_WR_A) ? nr : nk;
	assign clim    = (kind == mme_pkg::KIND_WR_A) ? nk : nc;
	assign oob     = (kind != mme_pkg::KIND_WR_A && kind != mme_pkg::KIND_WR_B) ||
		row >= rlim || col >= clim;
	assign in_addr = cell_addr(IDX_W'(row), IDX_W'(col));
	assign accept  = in_valid && (state_q == mme_pkg::ST_IDLE);

	assign k_last    = DW'(k_q) == nk - DW'(1);
	assign c_last    = DW'(c_q) == nc - DW'(1);
	assign r_last    = DW'(r_q) == nr - DW'(1);
	assign elem_last = r_last && c_last;

	assign rd_addr_a = (state_q == mme_pkg::ST_IDLE) ? in_addr : cell_addr(r_q, k_q);
	assign rd_addr_b = (state_q == mme_pkg::ST_IDLE) ? in_addr : cell_addr(k_q, c_q);
	assign wr_addr   = wr_addr_q;
	assign wr_value  = value_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mme_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (kind == mme_pkg::KIND_COMPUTE) ?
						mme_pkg::ST_ISSUE : mme_pkg::ST_STATUS;
				end
			end
			mme_pkg::ST_STATUS: begin
				if (out_free) begin
					state_d = mme_pkg::ST_IDLE;
				end
			end
			mme_pkg::ST_ISSUE: begin
				if (k_last) begin
					state_d = mme_pkg::ST_WAIT;
				end
			end
			mme_pkg::ST_WAIT: begin
				if (mac_done && out_free) begin
					state_d = elem_last ? mme_pkg::ST_IDLE : mme_pkg::ST_ISSUE;
				end
			end
		endcase
	end

	always_comb begin
		in_stall      = (state_q != mme_pkg::ST_IDLE);
		ctrl_a        = '0;
		ctrl_b        = '0;
		tag           = '0;
		res           = '0;
		mac_clear     = 1'b0;
		ctrl_a.wr_add = add_q;
		ctrl_b.wr_add = add_q;
		unique case (state_q)
			mme_pkg::ST_IDLE: begin
				// fetch the old cell so an add can use it
				ctrl_a.rd_en = in_valid && !oob && (kind == mme_pkg::KIND_WR_A);
				ctrl_b.rd_en = in_valid && !oob && (kind == mme_pkg::KIND_WR_B);
			end
			mme_pkg::ST_STATUS: begin
				ctrl_a.wr_en = out_free && !err_q && !tgt_b_q;
				ctrl_b.wr_en = out_free && !err_q && tgt_b_q;
				res.load     = out_free;
				res.status   = err_q;
				res.last     = 1'b1;
			end
			mme_pkg::ST_ISSUE: begin
				ctrl_a.rd_en = 1'b1;
				ctrl_b.rd_en = 1'b1;
				tag.valid    = 1'b1;
				tag.first    = (k_q == '0);
				tag.last     = k_last;
			end
			mme_pkg::ST_WAIT: begin
				res.load    = mac_done && out_free;
				res.is_comp = 1'b1;
				res.last    = elem_last;
				res.row     = mme_pkg::POS_W'(r_q);
				res.col     = mme_pkg::POS_W'(c_q);
				mac_clear   = mac_done && out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mme_pkg::ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			k_q     <= '0;
			err_q   <= 1'b0;
			tgt_b_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				r_q     <= '0;
				c_q     <= '0;
				k_q     <= '0;
				err_q   <= oob;
				tgt_b_q <= (kind == mme_pkg::KIND_WR_B);
			end
			if (state_q == mme_pkg::ST_ISSUE) begin
				k_q <= k_last ? '0 : k_q + IDX_W'(1);
			end
			if (mac_clear && !elem_last) begin
				if (c_last) begin
					c_q <= '0;
					r_q <= r_q + IDX_W'(1);
				end else begin
					c_q <= c_q + IDX_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_addr_q <= in_addr;
			value_q   <= value;
			add_q     <= add_to_cell;
		end
	end

`ifndef SYNTHESIS
	a_issue_no_stale_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mme_pkg::ST_ISSUE) |-> !mac_done)
		else $error("previous sum still flagged while a new one is issued");
	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |-> out_free)
		else $error("result loaded into a full output register");
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl_a.rd_en && ctrl_a.wr_en) && !(ctrl_b.rd_en && ctrl_b.wr_en))
		else $error("store read and written in the same cycle");
`endif

endmodule

// ===== hdl/matrix_multiply_engine_core.sv =====
// top level of the matrix multiply engine: config, stores, mac unit, output register
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_write_en cfg_index cfg_data           | in
//  in      | in_valid in_stall kind row col value       | in / stall out
//          | add_to_cell                                |
//  out     | out_valid out_stall status out_row out_col | out / stall in
//          | product_value last                         |
//
// write beat: old cell fetched on accept, written with the status beat
// compute beat: one multiply-accumulate per cycle while products are issued, through the
//   single mac unit fed by one read port of each store, then a wait for the finished sum
// reset clears the stores through per-entry valid bits; no clearing pass
// a stalled output holds the result; a new result waits for the output register
module matrix_multiply_engine_core #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_en,
	input  logic [1:0]                        cfg_index,
	input  logic [mme_pkg::DIM_W-1:0]         cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [mme_pkg::DIM_W-1:0]         row,
	input  logic [mme_pkg::DIM_W-1:0]         col,
	input  logic signed [mme_pkg::VAL_W-1:0]  value,
	input  logic                              add_to_cell,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              status,
	output logic [mme_pkg::POS_W-1:0]         out_row,
	output logic [mme_pkg::POS_W-1:0]         out_col,
	output logic signed [mme_pkg::OUT_W-1:0]  product_value,
	output logic                              last
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int IDX_W = $clog2(MAX_DIM);
	localparam int DW    = mme_pkg::DIM_W;
	localparam logic [DW-1:0] MD = DW'(MAX_DIM);

	logic [DW-1:0] a_rows_q, inner_dim_q, b_cols_q;
	logic [DW-1:0] nr, nk, nc;

	mme_pkg::mme_mem_ctrl_t ctrl_a, ctrl_b;
	mme_pkg::mme_tag_t      tag;
	mme_pkg::mme_res_t      res;
	logic [AW-1:0]          rd_addr_a, rd_addr_b, wr_addr;
	logic signed [mme_pkg::VAL_W-1:0] wr_value;
	logic signed [ELEM_BITS-1:0]      a_data, b_data;
	logic                   mac_done, mac_clear;
	logic signed [mme_pkg::OUT_W-1:0] mac_result;
	logic                   out_free;

	logic                   out_valid_q;
	logic                   status_q, last_q;
	logic [mme_pkg::POS_W-1:0] row_q, col_q;
	logic signed [mme_pkg::OUT_W-1:0] value_q;

	function automatic logic [DW-1:0] eff_dim(logic [DW-1:0] d);
		if (d == '0) begin
			return DW'(1);
		end else if (d > MD) begin
			return MD;
		end
		return d;
	endfunction

	assign nr = eff_dim(a_rows_q);
	assign nk = eff_dim(inner_dim_q);
	assign nc = eff_dim(b_cols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= DW'(8);
			inner_dim_q <= DW'(8);
			b_cols_q    <= DW'(8);
		end else if (cfg_write_en) begin
			if (cfg_index == mme_pkg::CFG_A_ROWS) begin
				a_rows_q <= cfg_data;
			end
			if (cfg_index == mme_pkg::CFG_INNER_DIM) begin
				inner_dim_q <= cfg_data;
			end
			if (cfg_index == mme_pkg::CFG_B_COLS) begin
				b_cols_q <= cfg_data;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	mme_seq #(
		.MAX_DIM (MAX_DIM),
		.AW      (AW),
		.IDX_W   (IDX_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.row         (row),
		.col         (col),
		.value       (value),
		.add_to_cell (add_to_cell),
		.nr          (nr),
		.nk          (nk),
		.nc          (nc),
		.out_free    (out_free),
		.mac_done    (mac_done),
		.ctrl_a      (ctrl_a),
		.ctrl_b      (ctrl_b),
		.rd_addr_a   (rd_addr_a),
		.rd_addr_b   (rd_addr_b),
		.wr_addr     (wr_addr),
		.wr_value    (wr_value),
		.tag         (tag),
		.mac_clear   (mac_clear),
		.res         (res)
	);

	mme_store #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.EW    (ELEM_BITS)
	) u_store_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_a),
		.rd_addr  (rd_addr_a),
		.wr_addr  (wr_addr),
		.wr_value (wr_value),
		.rd_data  (a_data)
	);

	mme_store #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.EW    (ELEM_BITS)
	) u_store_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl_b),
		.rd_addr  (rd_addr_b),
		.wr_addr  (wr_addr),
		.wr_value (wr_value),
		.rd_data  (b_data)
	);

	mme_mac #(
		.MAX_DIM (MAX_DIM),
		.EW      (ELEM_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.tag    (tag),
		.clear  (mac_clear),
		.a      (a_data),
		.b      (b_data),
		.done   (mac_done),
		.result (mac_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			status_q <= res.status;
			last_q   <= res.last;
			row_q    <= res.row;
			col_q    <= res.col;
			value_q  <= res.is_comp ? mac_result : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_row       = row_q;
	assign out_col       = col_q;
	assign product_value = value_q;
	assign last          = last_q;

`ifndef SYNTHESIS
	a_error_beat_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q) |-> (value_q == '0 && row_q == '0 && col_q == '0 && last_q))
		else $error("error status beat carries element data");
`endif

endmodule
